// File: rtl/hsrc_pkg.sv
package hsrc_pkg;

  // Input item modes.
  localparam logic [2:0] MODE_ASSIGN      = 3'd0;
  localparam logic [2:0] MODE_CLEAR       = 3'd1;
  localparam logic [2:0] MODE_PRESS       = 3'd2;
  localparam logic [2:0] MODE_RELEASE_ALL = 3'd3;
  localparam logic [2:0] MODE_SYNC        = 3'd4;

  // Slot assignment kinds.
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_KEY      = 3'd1;
  localparam logic [2:0] KIND_CONSUMER = 3'd2;
  localparam logic [2:0] KIND_BUTTON   = 3'd3;
  localparam logic [2:0] KIND_DPAD     = 3'd4;

  // Report identifiers.
  localparam logic [1:0] RID_NONE     = 2'd0;
  localparam logic [1:0] RID_KEYBOARD = 2'd1;
  localparam logic [1:0] RID_CONSUMER = 2'd2;
  localparam logic [1:0] RID_GAMEPAD  = 2'd3;

  // Usage limits.
  localparam logic [9:0] KEY_USAGE_MAX = 10'h0E7;
  localparam logic [9:0] BUTTON_MAX    = 10'd16;
  localparam logic [9:0] DPAD_MAX      = 10'd7;

  // Report layout, counted over the whole 35-byte sequence.
  localparam int unsigned KB_BYTES     = 30;
  localparam int unsigned KB_BITS      = KB_BYTES * 8;
  localparam logic [5:0]  ITEM_CONS_LO = 6'd30;
  localparam logic [5:0]  ITEM_CONS_HI = 6'd31;
  localparam logic [5:0]  ITEM_BTN_LO  = 6'd32;
  localparam logic [5:0]  ITEM_BTN_HI  = 6'd33;
  localparam logic [5:0]  ITEM_HAT     = 6'd34;
  localparam logic [7:0]  HAT_CENTER   = 8'd8;

  // One stored slot assignment.
  typedef struct packed {
    logic [2:0] kind;
    logic [9:0] usage;
    logic [7:0] mods;
  } entry_t;

  // Control toward the slot table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic held_we;
    logic held_val;
    logic held_clr_all;
  } mem_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT,
    ST_RESP
  } state_e;

  // Validates an assignment against the rules of its kind.
  function automatic logic assign_ok(logic [2:0] kind, logic [9:0] usage, logic [7:0] mods);
    logic ok;
    case (kind)
      KIND_KEY:      ok = (usage <= KEY_USAGE_MAX) && ((usage != '0) || (mods != '0));
      KIND_CONSUMER: ok = (usage != '0) && (mods == '0);
      KIND_BUTTON:   ok = (usage >= 10'd1) && (usage <= BUTTON_MAX) && (mods == '0);
      KIND_DPAD:     ok = (usage <= DPAD_MAX) && (mods == '0);
      default:       ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Horizontal component of a d-pad direction, clockwise from up.
  function automatic logic signed [1:0] dir_x(logic [2:0] dir);
    logic signed [1:0] v;
    case (dir)
      3'd1, 3'd2, 3'd3: v = 2'sd1;
      3'd5, 3'd6, 3'd7: v = -2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

  // Vertical component of a d-pad direction, negative is up.
  function automatic logic signed [1:0] dir_y(logic [2:0] dir);
    logic signed [1:0] v;
    case (dir)
      3'd0, 3'd1, 3'd7: v = -2'sd1;
      3'd3, 3'd4, 3'd5: v = 2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/hsrc_slot_mem.sv
module hsrc_slot_mem #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned IDX_W     = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsrc_pkg::mem_ctl_t ctl_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  hsrc_pkg::entry_t  wr_data_i,
  output hsrc_pkg::entry_t  rd_entry_o,
  output logic              rd_held_o
);

  hsrc_pkg::entry_t mem [NUM_SLOTS];
  hsrc_pkg::entry_t rd_data_q;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [NUM_SLOTS-1:0] held_q, held_d;
  logic rd_valid_q;
  logic rd_held_q;

  // Slot table storage with a registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Per-entry valid bits stand in for the cleared reset contents.
  always_comb begin
    valid_d = valid_q;
    if (ctl_i.wr_en) begin
      valid_d[wr_addr_i] = 1'b1;
    end
  end

  // Held bits live in flops so that a release-all clears them all at once.
  always_comb begin
    held_d = held_q;
    if (ctl_i.held_clr_all) begin
      held_d = '0;
    end else if (ctl_i.held_we) begin
      held_d[wr_addr_i] = ctl_i.held_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      held_q     <= '0;
      rd_valid_q <= 1'b0;
      rd_held_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      held_q  <= held_d;
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
        rd_held_q  <= held_q[rd_addr_i];
      end
    end
  end

  // An entry that was never written reads as an empty slot.
  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;
  assign rd_held_o  = rd_held_q;

endmodule

// File: rtl/hsrc_accum.sv
module hsrc_accum (
  input  logic             clk_i,
  input  logic             clr_i,
  input  logic             en_i,
  input  hsrc_pkg::entry_t entry_i,
  input  logic             held_i,
  input  logic [5:0]       item_i,
  output logic [1:0]       report_id_o,
  output logic [4:0]       byte_index_o,
  output logic [7:0]       data_byte_o,
  output logic             last_o
);

  // Byte 0 of the keyboard report holds modifiers, key u sets bit 8 + u.
  logic [hsrc_pkg::KB_BITS-1:0] kb_q, kb_d;
  logic [9:0]        cons_q, cons_d;
  logic [15:0]       btn_q, btn_d;
  logic signed [7:0] sx_q, sx_d, sy_q, sy_d;
  logic [7:0]        key_bit;
  logic [3:0]        btn_bit;
  logic xp, xn, yp, yn;
  logic [7:0] hat;

  assign key_bit = entry_i.usage[7:0] + 8'd8;
  assign btn_bit = 4'(entry_i.usage[4:0] - 5'd1);

  // Fold one held slot into the report accumulators.
  always_comb begin
    kb_d   = kb_q;
    cons_d = cons_q;
    btn_d  = btn_q;
    sx_d   = sx_q;
    sy_d   = sy_q;
    if (clr_i) begin
      kb_d   = '0;
      cons_d = '0;
      btn_d  = '0;
      sx_d   = '0;
      sy_d   = '0;
    end else if (en_i && held_i) begin
      case (entry_i.kind)
        hsrc_pkg::KIND_KEY: begin
          kb_d[7:0] = kb_q[7:0] | entry_i.mods;
          if ((entry_i.usage != '0) && (entry_i.usage <= hsrc_pkg::KEY_USAGE_MAX)) begin
            kb_d[key_bit] = 1'b1;
          end
        end
        hsrc_pkg::KIND_CONSUMER: begin
          if (cons_q == '0) begin
            cons_d = entry_i.usage;
          end
        end
        hsrc_pkg::KIND_BUTTON: begin
          if ((entry_i.usage >= 10'd1) && (entry_i.usage <= hsrc_pkg::BUTTON_MAX)) begin
            btn_d[btn_bit] = 1'b1;
          end
        end
        hsrc_pkg::KIND_DPAD: begin
          sx_d = sx_q + 8'(hsrc_pkg::dir_x(entry_i.usage[2:0]));
          sy_d = sy_q + 8'(hsrc_pkg::dir_y(entry_i.usage[2:0]));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    kb_q   <= kb_d;
    cons_q <= cons_d;
    btn_q  <= btn_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
  end

  // Hat value from the signs of the summed d-pad vector.
  always_comb begin
    xp = !sx_q[7] && (sx_q != '0);
    xn = sx_q[7];
    yp = !sy_q[7] && (sy_q != '0);
    yn = sy_q[7];
    if (!xp && !xn && yn)      hat = 8'd0;
    else if (xp && yn)         hat = 8'd1;
    else if (xp && !yp && !yn) hat = 8'd2;
    else if (xp && yp)         hat = 8'd3;
    else if (!xp && !xn && yp) hat = 8'd4;
    else if (xn && yp)         hat = 8'd5;
    else if (xn && !yp && !yn) hat = 8'd6;
    else if (xn && yn)         hat = 8'd7;
    else                       hat = hsrc_pkg::HAT_CENTER;
  end

  // Map the position in the 35-byte sequence to a report byte.
  always_comb begin
    last_o = 1'b0;
    case (item_i)
      hsrc_pkg::ITEM_CONS_LO: begin
        report_id_o  = hsrc_pkg::RID_CONSUMER;
        byte_index_o = 5'd0;
        data_byte_o  = cons_q[7:0];
      end
      hsrc_pkg::ITEM_CONS_HI: begin
        report_id_o  = hsrc_pkg::RID_CONSUMER;
        byte_index_o = 5'd1;
        data_byte_o  = {6'd0, cons_q[9:8]};
      end
      hsrc_pkg::ITEM_BTN_LO: begin
        report_id_o  = hsrc_pkg::RID_GAMEPAD;
        byte_index_o = 5'd0;
        data_byte_o  = btn_q[7:0];
      end
      hsrc_pkg::ITEM_BTN_HI: begin
        report_id_o  = hsrc_pkg::RID_GAMEPAD;
        byte_index_o = 5'd1;
        data_byte_o  = btn_q[15:8];
      end
      hsrc_pkg::ITEM_HAT: begin
        report_id_o  = hsrc_pkg::RID_GAMEPAD;
        byte_index_o = 5'd2;
        data_byte_o  = hat;
        last_o       = 1'b1;
      end
      default: begin
        report_id_o  = hsrc_pkg::RID_KEYBOARD;
        byte_index_o = item_i[4:0];
        data_byte_o  = kb_q[{item_i[4:0], 3'b000} +: 8];
      end
    endcase
  end

endmodule

// File: rtl/hid_slot_report_composer.sv
// Button slot table that composes HID keyboard, consumer and gamepad reports.
//
// Input channel (in_valid_i/in_ready_o) carries one command transaction: assign,
// clear, press or release a slot, release all slots, or request a report sync.
// Output channel (out_valid_o/out_ready_i) carries result transactions. A
// command that sends no reports yields one result with report_id 0 and last set.
// A command that sends reports while link_up_i is high yields 35 results: 30
// keyboard bytes, 2 consumer bytes and 3 gamepad bytes, the last one flagged.
//
// With reports, the slot table is walked one entry per cycle through the memory
// read port, then the bytes follow one per cycle while the receiver takes them.
// One command is in work at a time. A new command is accepted while the final
// result still waits in the output register. When the receiver stalls, the
// output register holds its transaction and the byte sequence pauses.
// Reset empties every slot and clears all held bits at once; no clearing
// pass is needed.
module hid_slot_report_composer #(
  parameter int unsigned NUM_SLOTS         = 16,
  parameter int unsigned FIRST_SLOT_NUMBER = 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] slot_i,
  input  logic [2:0] kind_i,
  input  logic [9:0] usage_i,
  input  logic [7:0] modifiers_i,
  input  logic       pressed_i,
  input  logic       link_up_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       status_o,
  output logic [1:0] report_id_o,
  output logic [4:0] byte_index_o,
  output logic [7:0] data_byte_o,
  output logic       last_o
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  hsrc_pkg::state_e state_q, state_d;

  // Latched command.
  logic [2:0]       mode_q;
  logic [2:0]       kind_q;
  logic [9:0]       usage_q;
  logic [7:0]       mods_q;
  logic             pressed_q, link_q, ok_q;
  logic [IDX_W-1:0] idx_q;
  logic             status_q, status_d;

  logic [IDX_W-1:0] wcnt_q, wcnt_d;
  logic [5:0]       item_q, item_d;
  logic             acc_vld_q, acc_vld_d;
  logic             acc_clr;

  logic [8:0]       diff_in;
  logic             in_ok;
  logic [IDX_W-1:0] in_idx;
  logic             in_fire;

  hsrc_pkg::mem_ctl_t ctl;
  logic [IDX_W-1:0]   rd_addr;
  hsrc_pkg::entry_t   wr_data;
  hsrc_pkg::entry_t   rd_entry;
  logic               rd_held;
  logic               assigned;
  logic               send_req;

  logic [1:0] acc_id;
  logic [4:0] acc_index;
  logic [7:0] acc_byte;
  logic       acc_last;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic       out_load, out_free;
  logic       ld_status, ld_last;
  logic [1:0] ld_id;
  logic [4:0] ld_index;
  logic [7:0] ld_byte;
  logic       out_status_q, out_last_q;
  logic [1:0] out_id_q;
  logic [4:0] out_index_q;
  logic [7:0] out_byte_q;

  // Slot range check on the incoming command.
  assign diff_in = {1'b0, slot_i} - 9'(FIRST_SLOT_NUMBER);
  assign in_ok   = !diff_in[8] && (diff_in < 9'(NUM_SLOTS));
  assign in_idx  = diff_in[IDX_W-1:0];

  assign in_ready_o = (state_q == hsrc_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign assigned   = (rd_entry.kind != hsrc_pkg::KIND_NONE);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q    <= mode_i;
      kind_q    <= kind_i;
      usage_q   <= usage_i;
      mods_q    <= modifiers_i;
      pressed_q <= pressed_i;
      link_q    <= link_up_i;
      ok_q      <= in_ok;
      idx_q     <= in_idx;
    end
  end

  // Sequencer: lookup, read-modify-write, then a table walk and byte emission, or a single result without a report.
  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    wcnt_d    = wcnt_q;
    item_d    = item_q;
    acc_vld_d = 1'b0;
    acc_clr   = 1'b0;
    send_req  = 1'b0;
    ctl       = '0;
    rd_addr   = wcnt_q;
    wr_data   = '0;
    out_load  = 1'b0;
    ld_status = status_q;
    ld_id     = hsrc_pkg::RID_NONE;
    ld_index  = '0;
    ld_byte   = '0;
    ld_last   = 1'b1;
    case (state_q)
      hsrc_pkg::ST_IDLE: begin
        rd_addr   = in_idx;
        ctl.rd_en = in_fire && in_ok;
        if (in_fire) begin
          state_d = hsrc_pkg::ST_EXEC;
        end
      end
      hsrc_pkg::ST_EXEC: begin
        status_d = 1'b0;
        case (mode_q)
          hsrc_pkg::MODE_ASSIGN: begin
            if (ok_q && hsrc_pkg::assign_ok(kind_q, usage_q, mods_q)) begin
              ctl.wr_en    = 1'b1;
              ctl.held_we  = 1'b1;
              wr_data.kind  = kind_q;
              wr_data.usage = usage_q;
              wr_data.mods  = mods_q;
              send_req     = 1'b1;
            end else begin
              status_d = 1'b1;
            end
          end
          hsrc_pkg::MODE_CLEAR: begin
            if (!ok_q) begin
              status_d = 1'b1;
            end else if (assigned) begin
              ctl.wr_en   = 1'b1;
              ctl.held_we = 1'b1;
              send_req    = 1'b1;
            end
          end
          hsrc_pkg::MODE_PRESS: begin
            // Stored entries were validated on assignment, so any kind means valid.
            if (!ok_q || !assigned) begin
              status_d = 1'b1;
            end else begin
              ctl.held_we  = 1'b1;
              ctl.held_val = link_q && pressed_q;
              send_req     = 1'b1;
            end
          end
          hsrc_pkg::MODE_RELEASE_ALL: begin
            ctl.held_clr_all = 1'b1;
          end
          hsrc_pkg::MODE_SYNC: begin
            send_req = 1'b1;
          end
          default: begin
          end
        endcase
        if (send_req && link_q) begin
          acc_clr = 1'b1;
          wcnt_d  = '0;
          state_d = hsrc_pkg::ST_WALK;
        end else begin
          state_d = hsrc_pkg::ST_RESP;
        end
      end
      hsrc_pkg::ST_WALK: begin
        ctl.rd_en = 1'b1;
        acc_vld_d = 1'b1;
        if (wcnt_q == LAST_IDX) begin
          state_d = hsrc_pkg::ST_DRAIN;
        end else begin
          wcnt_d = wcnt_q + 1'b1;
        end
      end
      hsrc_pkg::ST_DRAIN: begin
        // The last table entry is folded in during this cycle.
        item_d  = '0;
        state_d = hsrc_pkg::ST_EMIT;
      end
      hsrc_pkg::ST_EMIT: begin
        ld_id    = acc_id;
        ld_index = acc_index;
        ld_byte  = acc_byte;
        ld_last  = acc_last;
        if (out_free) begin
          out_load = 1'b1;
          if (acc_last) begin
            state_d = hsrc_pkg::ST_IDLE;
          end else begin
            item_d = item_q + 6'd1;
          end
        end
      end
      hsrc_pkg::ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = hsrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hsrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsrc_pkg::ST_IDLE;
      status_q    <= 1'b0;
      wcnt_q      <= '0;
      item_q      <= '0;
      acc_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      wcnt_q      <= wcnt_d;
      item_q      <= item_d;
      acc_vld_q   <= acc_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register keeps its transaction until the receiver takes it.
  assign out_valid_d = (out_valid_q && !out_ready_i) || out_load;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= ld_status;
      out_id_q     <= ld_id;
      out_index_q  <= ld_index;
      out_byte_q   <= ld_byte;
      out_last_q   <= ld_last;
    end
  end

  hsrc_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_slot_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (idx_q),
    .wr_data_i  (wr_data),
    .rd_entry_o (rd_entry),
    .rd_held_o  (rd_held)
  );

  hsrc_accum u_accum (
    .clk_i        (clk_i),
    .clr_i        (acc_clr),
    .en_i         (acc_vld_q),
    .entry_i      (rd_entry),
    .held_i       (rd_held),
    .item_i       (item_q),
    .report_id_o  (acc_id),
    .byte_index_o (acc_index),
    .data_byte_o  (acc_byte),
    .last_o       (acc_last)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign report_id_o  = out_id_q;
  assign byte_index_o = out_index_q;
  assign data_byte_o  = out_byte_q;
  assign last_o       = out_last_q;

endmodule

// File: rtl/hsrc_checker.sv
module hsrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] report_id_o,
  input logic [4:0] byte_index_o,
  input logic [7:0] data_byte_o,
  input logic       last_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o) && $stable(last_o))
    else $error("result changed while stalled");

  // A result without a report is a single, zeroed, final transaction.
  a_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (report_id_o == hsrc_pkg::RID_NONE) |->
      last_o && (byte_index_o == '0) && (data_byte_o == '0))
    else $error("empty result malformed");

  // Keyboard and consumer bytes never close the sequence; the hat byte does.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (report_id_o != hsrc_pkg::RID_NONE) |->
      (last_o == ((report_id_o == hsrc_pkg::RID_GAMEPAD) && (byte_index_o == 5'd2))))
    else $error("last flag on wrong report byte");

  // The hat byte is a direction or the center code.
  a_hat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (report_id_o == hsrc_pkg::RID_GAMEPAD) && (byte_index_o == 5'd2) |->
      (data_byte_o <= hsrc_pkg::HAT_CENTER))
    else $error("hat value out of range");

endmodule

bind hid_slot_report_composer hsrc_checker u_hsrc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .report_id_o  (report_id_o),
  .byte_index_o (byte_index_o),
  .data_byte_o  (data_byte_o),
  .last_o       (last_o)
);

// File: tb/tb_top.sv
module tb_top;

  localparam int unsigned SLOTS          = 16;
  localparam int unsigned BASE_SLOT      = 1;
  localparam int unsigned RANDOM_CMDS    = 400;
  localparam int unsigned QUIET_LIMIT    = 5000;
  localparam int unsigned LONG_HOLD      = 600;
  localparam int unsigned HOLD_AFTER     = 1000;
  localparam int unsigned TAIL_CYCLES    = 64;
  localparam logic [2:0]  MODE_UNKNOWN   = 3'd7;
  localparam logic [2:0]  KIND_INVALID   = 3'd7;

  // One command transaction as offered on the input channel.
  typedef struct {
    logic [2:0] mode;
    logic [7:0] slot;
    logic [2:0] kind;
    logic [9:0] usage;
    logic [7:0] mods;
    logic       pressed;
    logic       link;
    bit         drain_first;
  } cmd_t;

  // One result transaction as seen on the output channel.
  typedef struct {
    logic       status;
    logic [1:0] rid;
    logic [4:0] idx;
    logic [7:0] data;
    logic       last;
  } result_t;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] mode = '0;
  logic [7:0] slot = '0;
  logic [2:0] kind = '0;
  logic [9:0] usage = '0;
  logic [7:0] mods = '0;
  logic       pressed = 1'b0;
  logic       link_up = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       status;
  logic [1:0] report_id;
  logic [4:0] byte_index;
  logic [7:0] data_byte;
  logic       last;

  // Shadow copy of the slot table.
  logic [2:0] tbl_kind [SLOTS];
  logic [9:0] tbl_usage [SLOTS];
  logic [7:0] tbl_mods [SLOTS];
  logic       tbl_held [SLOTS];

  cmd_t        cmd_q[$];
  result_t     composed_q[$];
  cmd_t        cur_cmd;
  result_t     want;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  int unsigned cmds_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned report_sets = 0;
  int unsigned quiet_cycles = 0;
  int unsigned failures = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned seg_left = 0;
  int unsigned seg_style = 0;

  hid_slot_report_composer #(
    .NUM_SLOTS        (SLOTS),
    .FIRST_SLOT_NUMBER(BASE_SLOT)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .slot_i      (slot),
    .kind_i      (kind),
    .usage_i     (usage),
    .modifiers_i (mods),
    .pressed_i   (pressed),
    .link_up_i   (link_up),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .report_id_o (report_id),
    .byte_index_o(byte_index),
    .data_byte_o (data_byte),
    .last_o      (last)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Rules that a slot binding must meet for its kind.
  function automatic logic binding_ok(logic [2:0] k, logic [9:0] u, logic [7:0] m);
    case (k)
      hsrc_pkg::KIND_KEY:
        return (u <= hsrc_pkg::KEY_USAGE_MAX) && ((u != '0) || (m != '0));
      hsrc_pkg::KIND_CONSUMER:
        return (u != '0) && (m == '0);
      hsrc_pkg::KIND_BUTTON:
        return (u >= 10'd1) && (u <= hsrc_pkg::BUTTON_MAX) && (m == '0);
      hsrc_pkg::KIND_DPAD:
        return (u <= hsrc_pkg::DPAD_MAX) && (m == '0);
      default:
        return 1'b0;
    endcase
  endfunction

  // Horizontal and vertical steps of a d-pad direction, clockwise from up.
  function automatic int step_x(logic [2:0] d);
    case (d)
      3'd1, 3'd2, 3'd3: return 1;
      3'd5, 3'd6, 3'd7: return -1;
      default:          return 0;
    endcase
  endfunction

  function automatic int step_y(logic [2:0] d);
    case (d)
      3'd0, 3'd1, 3'd7: return -1;
      3'd3, 3'd4, 3'd5: return 1;
      default:          return 0;
    endcase
  endfunction

  task automatic push_result(input logic st, input logic [1:0] rid, input int unsigned idx,
                             input logic [7:0] data, input logic lst);
    result_t r;
    r.status = st;
    r.rid    = rid;
    r.idx    = 5'(idx);
    r.data   = data;
    r.last   = lst;
    composed_q.push_back(r);
  endtask

  // Builds the keyboard, consumer and gamepad reports from the held slots.
  task automatic push_reports(input logic st);
    logic [7:0]  kb [hsrc_pkg::KB_BYTES];
    logic [9:0]  cons;
    logic [15:0] btn;
    logic [7:0]  hat;
    logic [9:0]  u;
    int          sx;
    int          sy;
    int          hx;
    int          hy;
    cons = '0;
    btn  = '0;
    sx   = 0;
    sy   = 0;
    for (int i = 0; i < hsrc_pkg::KB_BYTES; i++) kb[i] = '0;
    for (int i = 0; i < SLOTS; i++) begin
      u = tbl_usage[i];
      if (tbl_held[i]) begin
        if (tbl_kind[i] == hsrc_pkg::KIND_KEY) begin
          kb[0] = kb[0] | tbl_mods[i];
          if ((u != '0) && (u <= hsrc_pkg::KEY_USAGE_MAX)) kb[1 + u / 8][u[2:0]] = 1'b1;
        end else if (tbl_kind[i] == hsrc_pkg::KIND_CONSUMER && cons == '0) begin
          cons = u;
        end else if (tbl_kind[i] == hsrc_pkg::KIND_BUTTON) begin
          if ((u >= 10'd1) && (u <= hsrc_pkg::BUTTON_MAX)) btn[u - 1] = 1'b1;
        end else if (tbl_kind[i] == hsrc_pkg::KIND_DPAD) begin
          sx += step_x(u[2:0]);
          sy += step_y(u[2:0]);
        end
      end
    end
    hx = (sx > 0) ? 1 : ((sx < 0) ? -1 : 0);
    hy = (sy > 0) ? 1 : ((sy < 0) ? -1 : 0);
    if (hx == 0 && hy < 0)      hat = 8'd0;
    else if (hx > 0 && hy < 0)  hat = 8'd1;
    else if (hx > 0 && hy == 0) hat = 8'd2;
    else if (hx > 0 && hy > 0)  hat = 8'd3;
    else if (hx == 0 && hy > 0) hat = 8'd4;
    else if (hx < 0 && hy > 0)  hat = 8'd5;
    else if (hx < 0 && hy == 0) hat = 8'd6;
    else if (hx < 0 && hy < 0)  hat = 8'd7;
    else                        hat = hsrc_pkg::HAT_CENTER;
    for (int i = 0; i < hsrc_pkg::KB_BYTES; i++) begin
      push_result(st, hsrc_pkg::RID_KEYBOARD, i, kb[i], 1'b0);
    end
    push_result(st, hsrc_pkg::RID_CONSUMER, 0, cons[7:0], 1'b0);
    push_result(st, hsrc_pkg::RID_CONSUMER, 1, {6'd0, cons[9:8]}, 1'b0);
    push_result(st, hsrc_pkg::RID_GAMEPAD, 0, btn[7:0], 1'b0);
    push_result(st, hsrc_pkg::RID_GAMEPAD, 1, btn[15:8], 1'b0);
    push_result(st, hsrc_pkg::RID_GAMEPAD, 2, hat, 1'b1);
  endtask

  // Updates the shadow table for one accepted command and queues its results.
  task automatic apply_command(input cmd_t c);
    logic        in_range;
    logic        st;
    logic        send;
    int unsigned ix;
    in_range = (int'(c.slot) >= BASE_SLOT) && (int'(c.slot) - BASE_SLOT < SLOTS);
    ix   = in_range ? int'(c.slot) - BASE_SLOT : 0;
    st   = 1'b0;
    send = 1'b0;
    case (c.mode)
      hsrc_pkg::MODE_ASSIGN: begin
        if (!in_range || !binding_ok(c.kind, c.usage, c.mods)) begin
          st = 1'b1;
        end else begin
          tbl_held[ix]  = 1'b0;
          tbl_kind[ix]  = c.kind;
          tbl_usage[ix] = c.usage;
          tbl_mods[ix]  = c.mods;
          send = 1'b1;
        end
      end
      hsrc_pkg::MODE_CLEAR: begin
        if (!in_range) begin
          st = 1'b1;
        end else if (tbl_kind[ix] != hsrc_pkg::KIND_NONE) begin
          tbl_held[ix]  = 1'b0;
          tbl_kind[ix]  = hsrc_pkg::KIND_NONE;
          tbl_usage[ix] = '0;
          tbl_mods[ix]  = '0;
          send = 1'b1;
        end
      end
      hsrc_pkg::MODE_PRESS: begin
        if (!in_range || !binding_ok(tbl_kind[ix], tbl_usage[ix], tbl_mods[ix])) begin
          st = 1'b1;
        end else if (!c.link) begin
          tbl_held[ix] = 1'b0;
        end else begin
          tbl_held[ix] = c.pressed;
          send = 1'b1;
        end
      end
      hsrc_pkg::MODE_RELEASE_ALL: begin
        for (int i = 0; i < SLOTS; i++) tbl_held[i] = 1'b0;
      end
      hsrc_pkg::MODE_SYNC: send = 1'b1;
      default: ;
    endcase
    if (send && c.link) push_reports(st);
    else push_result(st, hsrc_pkg::RID_NONE, 0, 8'd0, 1'b1);
  endtask

  task automatic add_cmd(input logic [2:0] md, input int unsigned sl, input logic [2:0] kd,
                         input int unsigned us, input int unsigned md_bits,
                         input logic prs, input logic lk);
    cmd_t c;
    c.mode        = md;
    c.slot        = 8'(sl);
    c.kind        = kd;
    c.usage       = 10'(us);
    c.mods        = 8'(md_bits);
    c.pressed     = prs;
    c.link        = lk;
    c.drain_first = 1'b0;
    cmd_q.push_back(c);
  endtask

  // Mostly well-formed commands with random content, plus some noise.
  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    pick          = $urandom_range(0, 99);
    c.drain_first = 1'b0;
    c.mode        = hsrc_pkg::MODE_SYNC;
    c.slot        = 8'(BASE_SLOT + $urandom_range(0, SLOTS - 1));
    c.kind        = 3'($urandom);
    c.usage       = 10'($urandom);
    c.mods        = 8'($urandom);
    c.pressed     = ($urandom_range(0, 9) < 6);
    c.link        = ($urandom_range(0, 99) < 85);
    if (pick < 25) begin
      c.mode = hsrc_pkg::MODE_ASSIGN;
      c.kind = 3'($urandom_range(1, 4));
      c.mods = '0;
      case (c.kind)
        hsrc_pkg::KIND_KEY: begin
          c.usage = 10'($urandom_range(0, 'hE7));
          if ($urandom_range(0, 2) == 0) c.mods = 8'($urandom);
          if (c.usage == '0 && c.mods == '0) c.usage = 10'd4;
        end
        hsrc_pkg::KIND_CONSUMER: c.usage = 10'($urandom_range(1, 1023));
        hsrc_pkg::KIND_BUTTON:   c.usage = 10'($urandom_range(1, 16));
        default:                 c.usage = 10'($urandom_range(0, 7));
      endcase
      // Now and then a binding that breaks a rule.
      if ($urandom_range(0, 9) == 0) begin
        c.kind  = 3'($urandom);
        c.usage = 10'($urandom);
        c.mods  = 8'($urandom);
      end
    end else if (pick < 32) begin
      c.mode = hsrc_pkg::MODE_CLEAR;
    end else if (pick < 67) begin
      c.mode = hsrc_pkg::MODE_PRESS;
    end else if (pick < 72) begin
      c.mode = hsrc_pkg::MODE_RELEASE_ALL;
    end else if (pick >= 90) begin
      c.mode = 3'($urandom);
      c.slot = 8'($urandom);
    end
    if ($urandom_range(0, 19) == 0) c.slot = 8'($urandom);
    return c;
  endfunction

  // Input driver: offers queued commands in bursts separated by gaps.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_command(cur_cmd);
        cmds_accepted <= cmds_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() == 0 ||
                     (cmd_q[0].drain_first && composed_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          cur_cmd = cmd_q.pop_front();
          mode     <= cur_cmd.mode;
          slot     <= cur_cmd.slot;
          kind     <= cur_cmd.kind;
          usage    <= cur_cmd.usage;
          mods     <= cur_cmd.mods;
          pressed  <= cur_cmd.pressed;
          link_up  <= cur_cmd.link;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end
      end
    end
  end

  // Receiver: segments of steady, random and periodic readiness, and one long hold.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_style = $urandom_range(0, 2);
        seg_left  = $urandom_range(20, 200);
      end
      seg_left--;
      case (seg_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (seg_left % 3 == 0);
      endcase
    end
  end

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      failures++;
    end
  endtask

  // Output monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (composed_q.size() == 0) begin
          $error("unexpected result: report_id %0d byte_index %0d data_byte %0d",
                 report_id, byte_index, data_byte);
          failures++;
        end else begin
          want = composed_q.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("report_id", 32'(want.rid), 32'(report_id));
          check_field("byte_index", 32'(want.idx), 32'(byte_index));
          check_field("data_byte", 32'(want.data), 32'(data_byte));
          check_field("last", 32'(want.last), 32'(last));
          if (want.rid == hsrc_pkg::RID_GAMEPAD && want.last) report_sets++;
        end
      end
    end
  end

  // Watchdog: gives up when neither channel moves for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    cmd_t c;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_kind[i]  = hsrc_pkg::KIND_NONE;
      tbl_usage[i] = '0;
      tbl_mods[i]  = '0;
      tbl_held[i]  = 1'b0;
    end

    // Directed commands: field extremes, each mode and the rejection rules.
    add_cmd(hsrc_pkg::MODE_SYNC, 1, hsrc_pkg::KIND_NONE, 0, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 1, hsrc_pkg::KIND_KEY, 'hE7, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 2, hsrc_pkg::KIND_KEY, 0, 'hFF, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 16, hsrc_pkg::KIND_CONSUMER, 'h3FF, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 3, hsrc_pkg::KIND_BUTTON, 16, 0, 1'b0, 1'b0);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 4, hsrc_pkg::KIND_DPAD, 7, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 5, hsrc_pkg::KIND_DPAD, 1, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 0, hsrc_pkg::KIND_KEY, 4, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 17, hsrc_pkg::KIND_KEY, 4, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 6, hsrc_pkg::KIND_NONE, 4, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 6, KIND_INVALID, 1, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 6, hsrc_pkg::KIND_KEY, 0, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 6, hsrc_pkg::KIND_KEY, 'hE8, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 6, hsrc_pkg::KIND_CONSUMER, 0, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 6, hsrc_pkg::KIND_BUTTON, 17, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_ASSIGN, 6, hsrc_pkg::KIND_DPAD, 3, 1, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_PRESS, 1, hsrc_pkg::KIND_NONE, 0, 0, 1'b1, 1'b1);
    add_cmd(hsrc_pkg::MODE_PRESS, 16, hsrc_pkg::KIND_NONE, 0, 0, 1'b1, 1'b1);
    add_cmd(hsrc_pkg::MODE_PRESS, 3, hsrc_pkg::KIND_NONE, 0, 0, 1'b1, 1'b1);
    add_cmd(hsrc_pkg::MODE_PRESS, 4, hsrc_pkg::KIND_NONE, 0, 0, 1'b1, 1'b1);
    add_cmd(hsrc_pkg::MODE_PRESS, 5, hsrc_pkg::KIND_NONE, 0, 0, 1'b1, 1'b1);
    add_cmd(hsrc_pkg::MODE_PRESS, 6, hsrc_pkg::KIND_NONE, 0, 0, 1'b1, 1'b1);
    add_cmd(hsrc_pkg::MODE_PRESS, 2, hsrc_pkg::KIND_NONE, 0, 0, 1'b1, 1'b0);
    add_cmd(hsrc_pkg::MODE_CLEAR, 7, hsrc_pkg::KIND_NONE, 0, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_CLEAR, 16, hsrc_pkg::KIND_NONE, 0, 0, 1'b0, 1'b1);
    add_cmd(hsrc_pkg::MODE_RELEASE_ALL, 1, hsrc_pkg::KIND_NONE, 0, 0, 1'b0, 1'b1);
    add_cmd(MODE_UNKNOWN, 1, hsrc_pkg::KIND_NONE, 0, 0, 1'b0, 1'b1);

    // Random commands; twice the sender waits for the block to drain first.
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      c = random_cmd();
      c.drain_first = (i == 0) || (i == RANDOM_CMDS / 2);
      cmd_q.push_back(c);
    end

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || in_valid) @(posedge clk_i);
    while (composed_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d commands and %0d result transactions, %0d full report sets.",
             cmds_accepted, results_seen, report_sets);
    $display("Included bursty input, receiver stalls, a long output hold and drain pauses.");
    if (failures == 0 && composed_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hsrc_pkg.sv
rtl/hsrc_slot_mem.sv
rtl/hsrc_accum.sv
rtl/hid_slot_report_composer.sv
rtl/hsrc_checker.sv
tb/tb_top.sv
